>>> rtl/core/epr_pkg.sv
// Package for the echo pulse ranging block.
// Holds widths, saturation limits, controller states and the
// command/status structs shared by the controller and the datapath.
package epr_pkg;

  localparam int TICK_BITS    = 24;
  localparam int COUNT_BITS   = 16;
  localparam int SCALE_BITS   = 20;
  localparam int DIST_BITS    = 24;
  localparam int SUM_BITS     = 40;
  localparam int DEV_BITS     = 64;
  localparam int SPREAD_BITS  = 48;
  localparam int SQ_BITS      = 2 * DIST_BITS;
  localparam int PROD_BITS    = TICK_BITS + SCALE_BITS;
  localparam int FRAC_SHIFT   = 8;
  localparam int DIV_BITS     = DEV_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_BITS);
  localparam int PADDR_BITS   = 3;
  localparam int PDATA_BITS   = 32;

  localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(11141);
  localparam logic                  REG_SCALE   = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_SQR,
    ST_DEV,
    ST_SPREAD_GO,
    ST_SPREAD_WAIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic tick;
    logic mul;
    logic acc;
    logic div_start;
    logic sel_spread;
    logic latch_mean;
    logic sqr;
    logic dev;
    logic latch_spread;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic fire;
    logic upd;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/core/epr_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on epr_pkg for the dividend and divisor widths.
module epr_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [epr_pkg::DIV_BITS-1:0]   dividend_i,
  input  logic [epr_pkg::COUNT_BITS-1:0] divisor_i,
  output logic                         done_o,
  output logic [epr_pkg::DIV_BITS-1:0]   quotient_o
);
  import epr_pkg::*;

  localparam logic [DIV_CNT_BITS-1:0] LAST_STEP = DIV_CNT_BITS'(DIV_BITS - 1);

  logic                    run_q, done_q;
  logic [DIV_CNT_BITS-1:0] cnt_q;
  logic [DIV_BITS-1:0]     num_q;
  logic [COUNT_BITS-1:0]   rem_q;
  logic [COUNT_BITS:0]     trial;
  logic                    take;

  assign trial = {rem_q, num_q[DIV_BITS-1]};
  assign take  = trial >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
    end else if (run_q) begin
      num_q <= {num_q[DIV_BITS-2:0], take};
      rem_q <= take ? COUNT_BITS'(trial - {1'b0, divisor_i}) : trial[COUNT_BITS-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

endmodule

>>> rtl/core/epr_datapath.sv
// Datapath: edge detection, tick counter, scaling multiplier, statistics
// accumulators, shared divider and output register. Uses epr_pkg, epr_div.
module epr_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  epr_pkg::cmd_t                   cmd_i,
  output epr_pkg::sts_t                   sts_o,
  input  logic                            echo_level_i,
  input  logic [epr_pkg::SCALE_BITS-1:0]  scale_i,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output logic [epr_pkg::DIST_BITS-1:0]   distance_q8_o,
  output logic [epr_pkg::DIST_BITS-1:0]   mean_q8_o,
  output logic [epr_pkg::SPREAD_BITS-1:0] spread_q16_o,
  output logic [epr_pkg::COUNT_BITS-1:0]  sample_count_o,
  output logic                            stats_full_o
);
  import epr_pkg::*;

  logic                   armed_q, last_q;
  logic [TICK_BITS-1:0]   ticks_q;
  logic [COUNT_BITS-1:0]  count_q;
  logic [SUM_BITS-1:0]    sum_q;
  logic [DEV_BITS-1:0]    dev_q;
  logic                   upd_q;
  logic [DIST_BITS-1:0]   dist_q, mean_q;
  logic [SQ_BITS-1:0]     sq_q;
  logic [SPREAD_BITS-1:0] spread_q;
  logic                   out_valid_q;

  logic                   rising, falling;
  logic [PROD_BITS-1:0]   prod;
  logic [PROD_BITS-FRAC_SHIFT-1:0] prod_sh;
  logic [DIST_BITS-1:0]   dist_d;
  logic [SUM_BITS:0]      sum_ext;
  logic [DEV_BITS:0]      dev_ext;
  logic [DIST_BITS-1:0]   diff;
  logic [DIV_BITS-1:0]    div_dividend, quo;
  logic                   div_done;

  assign rising  = echo_level_i && !last_q;
  assign falling = !echo_level_i && last_q;

  assign prod    = PROD_BITS'(ticks_q) * PROD_BITS'(scale_i);
  assign prod_sh = prod[PROD_BITS-1:FRAC_SHIFT];
  assign dist_d  = (|prod_sh[PROD_BITS-FRAC_SHIFT-1:DIST_BITS]) ? '1
                 : prod_sh[DIST_BITS-1:0];

  assign sum_ext = {1'b0, sum_q} + (SUM_BITS+1)'(dist_q);
  assign dev_ext = {1'b0, dev_q} + (DEV_BITS+1)'(sq_q);
  assign diff    = (dist_q >= mean_q) ? dist_q - mean_q : mean_q - dist_q;

  assign div_dividend = cmd_i.sel_spread ? dev_q : DIV_BITS'(sum_q);

  epr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      last_q      <= 1'b0;
      ticks_q     <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      dev_q       <= '0;
      upd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.tick) begin
        last_q <= echo_level_i;
        if (rising) begin
          armed_q <= 1'b1;
          ticks_q <= '0;
        end else begin
          if (armed_q && !(&ticks_q)) begin
            ticks_q <= ticks_q + 1'b1;
          end
          if (falling) begin
            armed_q <= 1'b0;
          end
        end
      end
      if (cmd_i.acc) begin
        upd_q <= !(&count_q);
        if (!(&count_q)) begin
          count_q <= count_q + 1'b1;
          sum_q   <= sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
        end
      end
      if (cmd_i.dev) begin
        dev_q <= dev_ext[DEV_BITS] ? '1 : dev_ext[DEV_BITS-1:0];
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      dist_q <= dist_d;
    end
    if (cmd_i.latch_mean) begin
      mean_q <= (|quo[DIV_BITS-1:DIST_BITS]) ? '1 : quo[DIST_BITS-1:0];
    end
    if (cmd_i.sqr) begin
      sq_q <= SQ_BITS'(diff) * SQ_BITS'(diff);
    end
    if (cmd_i.latch_spread) begin
      spread_q <= (|quo[DIV_BITS-1:SPREAD_BITS]) ? '1 : quo[SPREAD_BITS-1:0];
    end
    if (cmd_i.load_out) begin
      distance_q8_o  <= dist_q;
      mean_q8_o      <= mean_q;
      spread_q16_o   <= spread_q;
      sample_count_o <= count_q;
      stats_full_o   <= &count_q;
    end
  end

  assign sts_o.fire     = falling && armed_q;
  assign sts_o.upd      = upd_q;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;

endmodule

>>> rtl/core/epr_ctrl.sv
// Controller: sequences one measurement through the datapath.
// Depends on epr_pkg for states and the command/status structs.
module epr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  epr_pkg::sts_t sts_i,
  output epr_pkg::cmd_t cmd_o
);
  import epr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.tick = in_valid_i;
        if (in_valid_i && sts_i.fire) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = ST_MEAN_GO;
      end
      ST_MEAN_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.latch_mean = 1'b1;
          state_d = sts_i.upd ? ST_SQR : ST_SPREAD_GO;
        end
      end
      ST_SQR: begin
        cmd_o.sqr = 1'b1;
        state_d   = ST_DEV;
      end
      ST_DEV: begin
        cmd_o.dev = 1'b1;
        state_d   = ST_SPREAD_GO;
      end
      ST_SPREAD_GO: begin
        cmd_o.div_start  = 1'b1;
        cmd_o.sel_spread = 1'b1;
        state_d          = ST_SPREAD_WAIT;
      end
      ST_SPREAD_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.latch_spread = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/echo_pulse_ranging_with_stats_top.sv
// Top level of the echo pulse ranging block with running statistics.
// Depends on epr_pkg, epr_ctrl, epr_datapath; holds the APB scale register.

// One input transaction is one timebase tick carrying the echo level. A tick
// that does not end an armed pulse is taken in the idle state. A falling edge
// that ends an armed pulse produces one result and stalls the input until the
// result is loaded; once the sample count is full, the squared deviation is
// no longer accumulated. The single shared divider yields one quotient bit per
// cycle over 64 bits and runs twice per result, for the mean and for the
// spread. A finished result waits in the output register while new ticks are
// taken. The scale register sits at APB address 0 and reads back.
module echo_pulse_ranging_with_stats_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [epr_pkg::PADDR_BITS-1:0]  paddr,
  input  logic [epr_pkg::PDATA_BITS-1:0]  pwdata,
  output logic [epr_pkg::PDATA_BITS-1:0]  prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            echo_level_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [epr_pkg::DIST_BITS-1:0]   distance_q8_o,
  output logic [epr_pkg::DIST_BITS-1:0]   mean_q8_o,
  output logic [epr_pkg::SPREAD_BITS-1:0] spread_q16_o,
  output logic [epr_pkg::COUNT_BITS-1:0]  sample_count_o,
  output logic                            stats_full_o
);
  import epr_pkg::*;

  logic [SCALE_BITS-1:0] scale_q;
  cmd_t                  cmd;
  sts_t                  sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SCALE) ? PDATA_BITS'(scale_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_SCALE)) begin
      scale_q <= pwdata[SCALE_BITS-1:0];
    end
  end

  epr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  epr_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .echo_level_i   (echo_level_i),
    .scale_i        (scale_q),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .distance_q8_o  (distance_q8_o),
    .mean_q8_o      (mean_q8_o),
    .spread_q16_o   (spread_q16_o),
    .sample_count_o (sample_count_o),
    .stats_full_o   (stats_full_o)
  );

endmodule

>>> rtl/core/epr_checker.sv
// Port-level checker for the echo pulse ranging block, bound to the top.
// Depends on epr_pkg for field widths.
module epr_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            echo_level_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [epr_pkg::DIST_BITS-1:0]   distance_q8_o,
  input logic [epr_pkg::COUNT_BITS-1:0]  sample_count_o,
  input logic                            stats_full_o
);
  import epr_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(distance_q8_o)
      && $stable(sample_count_o))
    else $error("stalled result transaction changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (stats_full_o == (&sample_count_o)))
    else $error("full flag disagrees with sample count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sample_count_o != '0))
    else $error("result with zero sample count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !echo_level_i))
    else $error("measurement started without a low-level tick transaction");

endmodule

bind echo_pulse_ranging_with_stats_top epr_checker u_epr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .echo_level_i   (echo_level_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .distance_q8_o  (distance_q8_o),
  .sample_count_o (sample_count_o),
  .stats_full_o   (stats_full_o)
);

>>> tb/tb.sv
// Testbench for echo_pulse_ranging_with_stats_top: drives echo ticks and APB scale writes.
// A scoreboard class predicts distance, mean, spread and count for each echo pulse.
// Depends on epr_pkg and the RTL of the block only.
module tb;
  import epr_pkg::*;

  typedef struct packed {
    logic [DIST_BITS-1:0]   distance;
    logic [DIST_BITS-1:0]   mean;
    logic [SPREAD_BITS-1:0] spread;
    logic [COUNT_BITS-1:0]  count;
    logic                   full;
  } range_result_t;

  localparam logic [63:0] DIST_LIMIT   = (64'd1 << DIST_BITS) - 64'd1;
  localparam logic [63:0] SUM_LIMIT    = (64'd1 << SUM_BITS) - 64'd1;
  localparam logic [63:0] SPREAD_LIMIT = (64'd1 << SPREAD_BITS) - 64'd1;
  localparam logic [PADDR_BITS-1:0] SCALE_ADDR = {REG_SCALE, 2'b00};
  localparam int unsigned SCALE_MIN      = 1;
  localparam int unsigned SCALE_TOP      = (1 << SCALE_BITS) - 1;
  localparam int unsigned LONG_PULSE     = 600;
  localparam int unsigned RANDOM_ITEMS   = 300;
  localparam int unsigned DRAIN_CYCLES   = 200;
  localparam int unsigned HOLD_OFF_LEN   = 1500;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  class echo_range_checker;
    logic [SCALE_BITS-1:0] scale;
    logic                  armed;
    logic                  last_level;
    logic [TICK_BITS-1:0]  pulse_len;
    logic [SUM_BITS-1:0]   dist_total;
    logic [DEV_BITS-1:0]   dev_total;
    logic [COUNT_BITS-1:0] n_meas;
    range_result_t         pending_ranges[$];
    int                    errors;

    function new();
      scale      = SCALE_RESET;
      armed      = 1'b0;
      last_level = 1'b0;
      pulse_len  = '0;
      dist_total = '0;
      dev_total  = '0;
      n_meas     = '0;
      errors     = 0;
    endfunction

    function void note_tick(input logic level);
      logic [63:0]   mm_q8;
      logic [63:0]   total;
      logic [63:0]   cnt;
      logic [63:0]   avg;
      logic [63:0]   diff;
      logic [63:0]   sq;
      logic [63:0]   spread;
      logic          rising;
      logic          fire;
      range_result_t res;
      rising     = level && !last_level;
      fire       = !level && last_level && armed;
      last_level = level;
      if (rising) begin
        armed     = 1'b1;
        pulse_len = '0;
        return;
      end
      if (armed && pulse_len != {TICK_BITS{1'b1}}) pulse_len = pulse_len + 1'b1;
      if (!fire) return;
      armed = 1'b0;
      mm_q8 = 64'(pulse_len);
      total = 64'(scale);
      mm_q8 = (mm_q8 * total) >> FRAC_SHIFT;
      if (mm_q8 > DIST_LIMIT) mm_q8 = DIST_LIMIT;
      if (n_meas != {COUNT_BITS{1'b1}}) begin
        total = 64'(dist_total);
        total = total + mm_q8;
        if (total > SUM_LIMIT) total = SUM_LIMIT;
        dist_total = total[SUM_BITS-1:0];
        n_meas     = n_meas + 1'b1;
        cnt        = 64'(n_meas);
        avg        = total / cnt;
        diff       = (mm_q8 >= avg) ? mm_q8 - avg : avg - mm_q8;
        sq         = diff * diff;
        if (dev_total > ~sq) dev_total = '1;
        else dev_total = dev_total + sq;
      end
      total  = 64'(dist_total);
      cnt    = 64'(n_meas);
      avg    = (cnt != 0) ? total / cnt : 64'd0;
      spread = (cnt != 0) ? dev_total / cnt : 64'd0;
      if (avg > DIST_LIMIT) avg = DIST_LIMIT;
      if (spread > SPREAD_LIMIT) spread = SPREAD_LIMIT;
      res.distance = mm_q8[DIST_BITS-1:0];
      res.mean     = avg[DIST_BITS-1:0];
      res.spread   = spread[SPREAD_BITS-1:0];
      res.count    = n_meas;
      res.full     = (n_meas == {COUNT_BITS{1'b1}});
      pending_ranges.push_back(res);
    endfunction

    function void check_result(input range_result_t got);
      range_result_t want;
      if (pending_ranges.size() == 0) begin
        $error("unexpected result: distance_q8 %0d, sample_count %0d", got.distance, got.count);
        errors++;
        return;
      end
      want = pending_ranges.pop_front();
      if (got.distance !== want.distance) begin
        $error("distance_q8: expected %0d, actual %0d", want.distance, got.distance);
        errors++;
      end
      if (got.mean !== want.mean) begin
        $error("mean_q8: expected %0d, actual %0d", want.mean, got.mean);
        errors++;
      end
      if (got.spread !== want.spread) begin
        $error("spread_q16: expected %0d, actual %0d", want.spread, got.spread);
        errors++;
      end
      if (got.count !== want.count) begin
        $error("sample_count: expected %0d, actual %0d", want.count, got.count);
        errors++;
      end
      if (got.full !== want.full) begin
        $error("stats_full: expected %0d, actual %0d", want.full, got.full);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i        = 1'b0;
  logic                   rst_ni       = 1'b0;
  logic                   psel         = 1'b0;
  logic                   penable      = 1'b0;
  logic                   pwrite       = 1'b0;
  logic [PADDR_BITS-1:0]  paddr        = '0;
  logic [PDATA_BITS-1:0]  pwdata       = '0;
  logic [PDATA_BITS-1:0]  prdata;
  logic                   pready;
  logic                   in_valid_i   = 1'b0;
  logic                   in_stall_o;
  logic                   echo_level_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_stall_i  = 1'b0;
  logic [DIST_BITS-1:0]   distance_q8_o;
  logic [DIST_BITS-1:0]   mean_q8_o;
  logic [SPREAD_BITS-1:0] spread_q16_o;
  logic [COUNT_BITS-1:0]  sample_count_o;
  logic                   stats_full_o;

  echo_range_checker ranging;
  range_result_t     seen_range;
  int unsigned       ticks_sent  = 0;
  int unsigned       calm_left   = 0;
  int unsigned       idle_cycles = 0;
  bit                hold_off_req  = 1'b0;
  bit                hold_off_done = 1'b0;

  echo_pulse_ranging_with_stats_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .echo_level_i  (echo_level_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .distance_q8_o (distance_q8_o),
    .mean_q8_o     (mean_q8_o),
    .spread_q16_o  (spread_q16_o),
    .sample_count_o(sample_count_o),
    .stats_full_o  (stats_full_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic int unsigned pulse_high();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 12);
    if (r < 97) return $urandom_range(13, 200);
    return $urandom_range(201, 600);
  endfunction

  task automatic send_tick(input logic level);
    int unsigned gap;
    if (calm_left > 0) begin
      gap = 0;
      calm_left--;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 99) < 2) calm_left = $urandom_range(20, 120);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    echo_level_i <= level;
    do @(posedge clk_i); while (in_stall_o);
    ranging.note_tick(level);
    ticks_sent++;
  endtask

  task automatic send_run(input logic level, input int unsigned n);
    repeat (n) send_tick(level);
  endtask

  task automatic send_pulse(input int unsigned high_len, input int unsigned low_len);
    send_run(1'b1, high_len);
    send_run(1'b0, low_len);
  endtask

  task automatic finish_phase();
    in_valid_i <= 1'b0;
    while (ranging.pending_ranges.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_scale(input logic [SCALE_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SCALE_ADDR;
    pwdata  <= {{(PDATA_BITS-SCALE_BITS){1'b0}}, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    ranging.scale = value;
  endtask

  task automatic run_random(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned r;
    stop_at = ticks_sent + n_items;
    while (ticks_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        send_pulse(pulse_high(),
                   ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 60));
      end else if (r < 92) begin
        repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)));
      end else begin
        send_run(ranging.last_level, $urandom_range(5, 40));
      end
    end
  endtask

  initial begin : out_pacing
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_LEN) @(posedge clk_i);
        hold_off_done = 1'b1;
      end else if ($urandom_range(0, 99) < 65) begin
        out_stall_i <= 1'b0;
        if ($urandom_range(0, 99) < 90) repeat ($urandom_range(1, 40)) @(posedge clk_i);
        else repeat ($urandom_range(100, 300)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        repeat (1 + pick_gap()) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen_range.distance = distance_q8_o;
        seen_range.mean     = mean_q8_o;
        seen_range.spread   = spread_q16_o;
        seen_range.count    = sample_count_o;
        seen_range.full     = stats_full_o;
        ranging.check_result(seen_range);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    ranging = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_run(1'b0, 3);
    send_pulse(1, 1);
    send_pulse(2, 1);
    send_pulse(6, 3);
    finish_phase();
    write_scale(SCALE_BITS'(SCALE_MIN));
    send_pulse(1, 1);
    send_pulse(9, 2);
    finish_phase();
    write_scale(SCALE_BITS'(SCALE_TOP));
    send_pulse(1, 1);
    send_pulse(LONG_PULSE, 1);
    finish_phase();
    write_scale(SCALE_BITS'($urandom_range(SCALE_MIN, SCALE_TOP)));
    run_random(RANDOM_ITEMS);
    finish_phase();
    hold_off_req = 1'b1;
    write_scale(SCALE_BITS'(SCALE_TOP));
    run_random(RANDOM_ITEMS);
    finish_phase();
    write_scale(SCALE_BITS'(SCALE_MIN));
    run_random(RANDOM_ITEMS);
    finish_phase();
    write_scale(SCALE_BITS'($urandom_range(SCALE_MIN, 2000)));
    run_random(RANDOM_ITEMS);
    finish_phase();
    if (ranging.errors == 0 && ranging.pending_ranges.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
